@@ sv/tilde_hex_escape_codec_assert.svh @@
// Assertion macros shared by the codec's checker.
// Relies on signals clk and arst_n in the scope of each use.
`ifndef TILDE_HEX_ESCAPE_CODEC_ASSERT_SVH
`define TILDE_HEX_ESCAPE_CODEC_ASSERT_SVH

// same-cycle implication, checked outside reset
`define THEC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("thec assertion failed");

// next-cycle implication, checked outside reset
`define THEC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("thec assertion failed");

`endif

@@ sv/thec_pkg.sv @@
// Types, codes and character helpers for the tilde hex escape codec.
// No dependencies; used by the top level and the testbench.
package thec_pkg;

	localparam int unsigned CFG_ADDR_W = 3;

	typedef enum logic [1:0] {
		MODE_ENCODE = 2'd0,
		MODE_DECODE = 2'd1,
		MODE_CLEAN  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_TILDE = 2'd1,
		PH_HIGH  = 2'd2
	} phase_t;

	localparam logic [0:0] REG_MODE = 1'b0;

	localparam logic [7:0] TILDE       = 8'h7E;
	localparam logic [7:0] SPACE       = 8'h20;
	localparam logic [7:0] ENC_LAST    = 8'h7D;
	localparam logic [7:0] CLEAN_LAST  = 8'h7E;
	localparam logic [7:0] DIGIT_ZERO  = 8'h30;
	localparam logic [7:0] DIGIT_NINE  = 8'h39;
	localparam logic [7:0] UPPER_A     = 8'h41;
	localparam logic [7:0] UPPER_F     = 8'h46;
	localparam logic [7:0] LOWER_A     = 8'h61;
	localparam logic [7:0] LOWER_F     = 8'h66;
	localparam logic [3:0] TEN         = 4'd10;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       last_of_run;
		logic       message_done;
		logic       error;
	} res_t;

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [3:0] d;
		d = v - TEN;
		if (v < TEN) begin
			hex_char = DIGIT_ZERO + {4'd0, v};
		end else begin
			hex_char = UPPER_A + {4'd0, d};
		end
	endfunction

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		hex_value = 5'h10;
		if (c >= DIGIT_ZERO && c <= DIGIT_NINE) begin
			d = c - DIGIT_ZERO;
			hex_value = {1'b0, d[3:0]};
		end else if (c >= UPPER_A && c <= UPPER_F) begin
			d = c - UPPER_A + {4'd0, TEN};
			hex_value = {1'b0, d[3:0]};
		end else if (c >= LOWER_A && c <= LOWER_F) begin
			d = c - LOWER_A + {4'd0, TEN};
			hex_value = {1'b0, d[3:0]};
		end
	endfunction

endpackage

@@ sv/thec_if.sv @@
// Valid/ready stream interfaces for the codec's input and result channels.
// No dependencies.
interface thec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_message;

	modport source(output valid, output in_byte, output end_of_message, input ready);
	modport sink(input valid, input in_byte, input end_of_message, output ready);
endinterface

interface thec_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       last_of_run;
	logic       message_done;
	logic       error;

	modport source(output valid, output out_byte, output has_byte, output last_of_run,
		output message_done, output error, input ready);
	modport sink(input valid, input out_byte, input has_byte, input last_of_run,
		input message_done, input error, output ready);
endinterface

@@ sv/tilde_hex_escape_codec.sv @@
// Top level of the tilde hex escape codec: mode register, input stage, result register.
// Depends on thec_pkg and the interfaces in thec_if.sv.
//
// Usage:
//  in_ch takes one byte per request with end_of_message marking a message's final byte.
//  out_ch returns result requests: a byte (has_byte) or a status-only item, with
//  last_of_run on the final result of an input byte and message_done on a message end.
//  mode is written over APB at address 0 (0 encode, 1 decode, 2 and 3 clean); the user
//  must write it only while the block is idle, which the block itself does not enforce.
// Timing:
//  A result is computed from the byte in the input stage and registered in the result
//  register. Pass-through bytes flow at one per cycle while out_ch is ready; an encoded
//  escape holds the input stage until its three results are emitted, since the result
//  register takes one result a cycle. Dropped bytes retire with no result.
// Reset:
//  arst_n clears mode to encode, the escape state and both valid flags.
// Stall:
//  when out_ch is not ready a full result register holds, the input stage holds a byte that
//  still has results to give and in_ch.ready drops until the result register frees.
module tilde_hex_escape_codec (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [thec_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	thec_in_if.sink                         in_ch,
	thec_out_if.source                      out_ch
);
	import thec_pkg::*;

	logic [1:0] mode_q;
	phase_t     phase_q, phase_d;
	logic [3:0] hi_q, hi_d;
	logic       err_q, err_d;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       eom_s1;
	logic [1:0] idx_q;

	res_t       out_s2;
	logic       vld_s2;

	res_t       res;
	logic [1:0] n_res;
	logic [4:0] dig;
	logic       out_free, emit, retire, in_acc, cfg_wr;

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_MODE);
	assign prdata = (paddr[CFG_ADDR_W-1] == REG_MODE) ? {30'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENCODE;
		end else if (cfg_wr) begin
			mode_q <= pwdata[1:0];
		end
	end

	// result selection for the byte in the input stage
	always_comb begin
		n_res   = 2'd0;
		res     = '0;
		phase_d = phase_q;
		hi_d    = hi_q;
		err_d   = err_q;
		dig     = hex_value(byte_s1);
		case (mode_q)
			MODE_ENCODE: begin
				if (byte_s1 >= SPACE && byte_s1 <= ENC_LAST) begin
					n_res = 2'd1;
					res   = '{out_byte: byte_s1, has_byte: 1'b1, last_of_run: 1'b1,
						message_done: eom_s1, error: 1'b0};
				end else begin
					n_res            = 2'd3;
					res.has_byte     = 1'b1;
					res.last_of_run  = (idx_q == 2'd2);
					res.message_done = (idx_q == 2'd2) && eom_s1;
					case (idx_q)
						2'd0:    res.out_byte = TILDE;
						2'd1:    res.out_byte = hex_char(byte_s1[7:4]);
						default: res.out_byte = hex_char(byte_s1[3:0]);
					endcase
				end
			end
			MODE_DECODE: begin
				if (err_q) begin
					if (eom_s1) begin
						n_res = 2'd1;
						res   = '{out_byte: 8'd0, has_byte: 1'b0, last_of_run: 1'b1,
							message_done: 1'b1, error: 1'b1};
					end
				end else if (phase_q == PH_IDLE) begin
					if (byte_s1 != TILDE) begin
						n_res = 2'd1;
						res   = '{out_byte: byte_s1, has_byte: 1'b1, last_of_run: 1'b1,
							message_done: eom_s1, error: 1'b0};
					end else if (eom_s1) begin
						n_res = 2'd1;
						res   = '{out_byte: 8'd0, has_byte: 1'b0, last_of_run: 1'b1,
							message_done: 1'b1, error: 1'b1};
					end else begin
						phase_d = PH_TILDE;
					end
				end else if (dig[4]) begin
					err_d   = 1'b1;
					phase_d = PH_IDLE;
					n_res   = 2'd1;
					res     = '{out_byte: 8'd0, has_byte: 1'b0, last_of_run: 1'b1,
						message_done: eom_s1, error: 1'b1};
				end else if (phase_q == PH_TILDE) begin
					if (eom_s1) begin
						n_res = 2'd1;
						res   = '{out_byte: 8'd0, has_byte: 1'b0, last_of_run: 1'b1,
							message_done: 1'b1, error: 1'b1};
					end else begin
						hi_d    = dig[3:0];
						phase_d = PH_HIGH;
					end
				end else begin
					phase_d = PH_IDLE;
					n_res   = 2'd1;
					res     = '{out_byte: {hi_q, dig[3:0]}, has_byte: 1'b1, last_of_run: 1'b1,
						message_done: eom_s1, error: 1'b0};
				end
			end
			default: begin
				if (byte_s1 >= SPACE && byte_s1 <= CLEAN_LAST) begin
					n_res = 2'd1;
					res   = '{out_byte: byte_s1, has_byte: 1'b1, last_of_run: 1'b1,
						message_done: eom_s1, error: 1'b0};
				end else if (eom_s1) begin
					n_res = 2'd1;
					res   = '{out_byte: 8'd0, has_byte: 1'b0, last_of_run: 1'b1,
						message_done: 1'b1, error: 1'b0};
				end
			end
		endcase
		if (eom_s1) begin
			phase_d = PH_IDLE;
			hi_d    = 4'd0;
			err_d   = 1'b0;
		end
	end

	assign out_free    = !vld_s2 || out_ch.ready;
	assign emit        = vld_s1 && (n_res != 2'd0) && out_free;
	assign retire      = vld_s1 && ((n_res == 2'd0) || (out_free && (idx_q == n_res - 2'd1)));
	assign in_ch.ready = !vld_s1 || retire;
	assign in_acc      = in_ch.valid && in_ch.ready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			idx_q  <= 2'd0;
		end else begin
			if (in_acc) begin
				vld_s1 <= 1'b1;
			end else if (retire) begin
				vld_s1 <= 1'b0;
			end
			if (retire) begin
				idx_q <= 2'd0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= in_ch.in_byte;
			eom_s1  <= in_ch.end_of_message;
		end
	end

	// escape state, committed when the byte retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hi_q    <= 4'd0;
			err_q   <= 1'b0;
		end else if (retire) begin
			phase_q <= phase_d;
			hi_q    <= hi_d;
			err_q   <= err_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (emit) begin
			vld_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_s2 <= res;
		end
	end

	assign out_ch.valid        = vld_s2;
	assign out_ch.out_byte     = out_s2.out_byte;
	assign out_ch.has_byte     = out_s2.has_byte;
	assign out_ch.last_of_run  = out_s2.last_of_run;
	assign out_ch.message_done = out_s2.message_done;
	assign out_ch.error        = out_s2.error;

endmodule

@@ sv/thec_checker.sv @@
// Port-level checker for the tilde hex escape codec, bound to the top level.
// Depends on tilde_hex_escape_codec_assert.svh.
module thec_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       has_byte,
	input logic       last_of_run,
	input logic       message_done,
	input logic       error
);
	`include "tilde_hex_escape_codec_assert.svh"

	// a stalled result holds
	`THEC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(has_byte) && $stable(message_done))
	// status-only results carry a zero byte
	`THEC_ASSERT_NOW(a_status_zero, out_valid && !has_byte, out_byte == 8'd0)
	// message end only on the last result of a byte
	`THEC_ASSERT_NOW(a_done_last, out_valid && message_done, last_of_run)
	// errors never travel with data
	`THEC_ASSERT_NOW(a_err_nodata, out_valid && error, !has_byte && last_of_run)

endmodule

bind tilde_hex_escape_codec thec_checker u_thec_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_byte     (out_ch.out_byte),
	.has_byte     (out_ch.has_byte),
	.last_of_run  (out_ch.last_of_run),
	.message_done (out_ch.message_done),
	.error        (out_ch.error)
);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for tilde_hex_escape_codec: encode, decode and clean modes.
// Uses thec_pkg, the stream interfaces in thec_if.sv and the codec top level.
import thec_pkg::*;

class escape_result_tracker;
	logic [1:0]  mode;
	phase_t      phase;
	logic [3:0]  high_nib;
	bit          err_latched;
	res_t        awaited[$];
	int unsigned mismatches;

	function new();
		mode = MODE_ENCODE;
		phase = PH_IDLE;
		high_nib = 4'd0;
		err_latched = 1'b0;
		mismatches = 0;
	endfunction

	function void set_mode(logic [1:0] m);
		mode = m;
	endfunction

	function void add(logic [7:0] b, bit has, bit last, bit done, bit err);
		res_t r;
		r = {b, has, last, done, err};
		awaited = {awaited, r};
	endfunction

	function logic [7:0] hex_digit(logic [3:0] v);
		return (v < TEN) ? DIGIT_ZERO + v : UPPER_A + v - TEN;
	endfunction

	// bit 4 set when c is no hex digit
	function logic [4:0] digit_value(logic [7:0] c);
		if (c inside {[DIGIT_ZERO:DIGIT_NINE]})
			return {1'b0, c[3:0]};
		if (c inside {[UPPER_A:UPPER_F]} || c inside {[LOWER_A:LOWER_F]})
			return {1'b0, c[3:0] + 4'd9};
		return 5'h10;
	endfunction

	function void decode_byte(logic [7:0] c, logic eom);
		logic [4:0] v;
		if (err_latched) begin
			if (eom)
				add(8'd0, 0, 1, 1, 1);
			return;
		end
		if (phase == PH_IDLE) begin
			if (c != TILDE)
				add(c, 1, 1, eom, 0);
			else if (eom)
				add(8'd0, 0, 1, 1, 1);
			else
				phase = PH_TILDE;
			return;
		end
		v = digit_value(c);
		if (v[4]) begin
			err_latched = 1'b1;
			phase = PH_IDLE;
			add(8'd0, 0, 1, eom, 1);
		end else if (phase == PH_TILDE) begin
			if (eom) begin
				add(8'd0, 0, 1, 1, 1);
			end else begin
				high_nib = v[3:0];
				phase = PH_HIGH;
			end
		end else begin
			phase = PH_IDLE;
			add({high_nib, v[3:0]}, 1, 1, eom, 0);
		end
	endfunction

	function void take_byte(logic [7:0] c, logic eom);
		if (mode == MODE_ENCODE) begin
			if (c >= SPACE && c <= ENC_LAST) begin
				add(c, 1, 1, eom, 0);
			end else begin
				add(TILDE, 1, 0, 0, 0);
				add(hex_digit(c[7:4]), 1, 0, 0, 0);
				add(hex_digit(c[3:0]), 1, 1, eom, 0);
			end
		end else if (mode == MODE_DECODE) begin
			decode_byte(c, eom);
		end else begin
			if (c >= SPACE && c <= CLEAN_LAST)
				add(c, 1, 1, eom, 0);
			else if (eom)
				add(8'd0, 0, 1, 1, 0);
		end
		if (eom) begin
			phase = PH_IDLE;
			high_nib = 4'd0;
			err_latched = 1'b0;
		end
	endfunction

	function void compare_result(res_t got);
		res_t want;
		if (awaited.size() == 0) begin
			$display("%0t: unexpected result byte %h has %b last %b done %b error %b",
				$time, got.out_byte, got.has_byte, got.last_of_run, got.message_done,
				got.error);
			mismatches++;
			return;
		end
		want = awaited.pop_front();
		if (got !== want) begin
			$display("%0t: expected byte %h has %b last %b done %b error %b", $time,
				want.out_byte, want.has_byte, want.last_of_run, want.message_done,
				want.error);
			$display("%0t: actual   byte %h has %b last %b done %b error %b", $time,
				got.out_byte, got.has_byte, got.last_of_run, got.message_done, got.error);
			mismatches++;
		end
	endfunction
endclass

module testbench;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam logic [1:0] MODE_CLEAN_ALIAS = 2'd3;
	localparam logic [CFG_ADDR_W-1:0] MODE_ADDR = {REG_MODE, 2'b00};
	localparam logic [7:0] BOUNDARY_BYTES [0:6] =
		'{8'h00, 8'h1F, SPACE, ENC_LAST, TILDE, 8'h7F, 8'hFF};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	thec_in_if  in_ch();
	thec_out_if out_ch();

	escape_result_tracker tracker = new();
	int unsigned accepted;
	int unsigned quiet_sends;
	int unsigned cycles;

	tilde_hex_escape_codec i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.out_byte, out_ch.has_byte, out_ch.last_of_run,
				out_ch.message_done, out_ch.error};
			tracker.compare_result(got);
		end
	end

	// result side: random stalls, one long hold-off once 120 bytes have been accepted
	initial begin
		int stall_left;
		int calm_left;
		int r;
		bit pressed;
		stall_left = 0;
		calm_left = 0;
		pressed = 1'b0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!pressed && accepted >= 120) begin
				pressed = 1'b1;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				r = $urandom_range(0, 99);
				if (calm_left > 0)
					calm_left--;
				else if (r < 12)
					stall_left = $urandom_range(1, 3);
				else if (r < 15)
					stall_left = $urandom_range(8, 40);
				else if (r < 18)
					calm_left = $urandom_range(20, 60);
			end
		end
	end

	task automatic send_request(input logic [7:0] c, input logic eom);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (quiet_sends > 0) begin
			quiet_sends--;
			gap = 0;
		end else if (r < 55) begin
			gap = 0;
		end else if (r < 88) begin
			gap = $urandom_range(1, 3);
		end else if (r < 96) begin
			gap = $urandom_range(6, 30);
		end else begin
			gap = 0;
			quiet_sends = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= c;
		in_ch.end_of_message <= eom;
		do @(posedge clk); while (!in_ch.ready);
		tracker.take_byte(c, eom);
		accepted++;
	endtask

	task automatic send_bytes(input logic [7:0] msg[$], input logic eom_last);
		foreach (msg[i])
			send_request(msg[i], eom_last && (i == msg.size() - 1));
	endtask

	function automatic logic [7:0] rand_digit();
		logic [7:0] v;
		v = 8'($urandom_range(0, 15));
		if (v < TEN)
			return DIGIT_ZERO + v;
		return ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + v - TEN;
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 9) < 3)
			return BOUNDARY_BYTES[3'($urandom_range(0, 6))];
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly well-formed escaped text, some broken escapes and stray bytes
	task automatic send_escaped_message();
		logic [7:0] q[$];
		logic [7:0] c;
		int n;
		int r;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				c = 8'($urandom_range(0, 255));
				if (c == TILDE)
					c = SPACE;
				q = {q, c};
			end else if (r < 85) begin
				q = {q, TILDE};
				q = {q, rand_digit()};
				q = {q, rand_digit()};
			end else if (r < 95) begin
				q = {q, TILDE};
				q = {q, 8'($urandom_range(0, 255))};
				if ($urandom_range(0, 1))
					q = {q, rand_digit()};
			end else begin
				q = {q, 8'($urandom_range(0, 255))};
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			q = {q, TILDE};
			if ($urandom_range(0, 1))
				q = {q, rand_digit()};
		end
		send_bytes(q, 1'b1);
	endtask

	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] m);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MODE_ADDR;
		pwdata <= {30'd0, m};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_mode(m);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {30'd0, m}) begin
			$display("%0t: mode read back %h, expected %h", $time, prdata, {30'd0, m});
			tracker.mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		logic [1:0] m;
		int unsigned start;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = 32'd0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'd0;
		in_ch.end_of_message = 1'b0;
		accepted = 0;
		quiet_sends = 0;
		cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// encode straight out of reset
		send_bytes('{8'h00, 8'hFF, SPACE, ENC_LAST, TILDE, 8'h7F}, 1'b1);
		settle();
		write_mode(MODE_DECODE);
		// both digit cases, then a bad digit and the dropped tail
		send_bytes('{TILDE, 8'h61, 8'h46, TILDE, 8'h47, 8'h78}, 1'b1);
		send_bytes('{TILDE}, 1'b1);
		send_bytes('{TILDE, 8'h39}, 1'b1);
		send_bytes('{TILDE, 8'h5A}, 1'b1);
		send_bytes('{8'h00}, 1'b1);
		// escape left open across mode changes
		send_bytes('{TILDE, 8'h34}, 1'b0);
		settle();
		write_mode(MODE_CLEAN);
		send_bytes('{8'h71}, 1'b0);
		settle();
		write_mode(MODE_DECODE);
		send_bytes('{8'h32}, 1'b1);
		settle();
		write_mode(MODE_CLEAN);
		send_bytes('{8'h1F, TILDE, 8'h7F}, 1'b1);
		settle();
		write_mode(MODE_CLEAN_ALIAS);
		send_bytes('{SPACE, 8'h05}, 1'b1);

		for (int p = 0; p < 8; p++) begin
			if (p < 4)
				m = p[1:0];
			else if ($urandom_range(0, 1))
				m = MODE_DECODE;
			else
				m = 2'($urandom_range(0, 3));
			settle();
			write_mode(m);
			start = accepted;
			while (accepted - start < 30) begin
				if (m == MODE_DECODE)
					send_escaped_message();
				else
					send_request(pick_byte(), $urandom_range(0, 5) == 0);
			end
		end
		settle();

		if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
			$display("testbench: clean");
		end else begin
			if (tracker.awaited.size() != 0)
				$display("%0t: %0d expected results never arrived", $time,
					tracker.awaited.size());
			$display("testbench: errors");
		end
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+sv
sv/thec_pkg.sv
sv/thec_if.sv
sv/tilde_hex_escape_codec.sv
sv/thec_checker.sv
bench/testbench.sv
